### sv/stsg_pkg.sv
// Shared types and constants of the sine table sample generator.
// Used by stsg_term_cell, the top level and the testbench; depends on nothing else.
`default_nettype none

package stsg_pkg;

    // Field and register widths
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned AMP_W      = 16;
    localparam int unsigned CODE_W     = 12;
    localparam int unsigned PROD_W     = IDX_W + CFG_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Default table resolution (phase steps per full turn)
    localparam int unsigned TABLE_DEPTH_DEF = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] POINTS_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] CYCLES_RST    = 13'd1;
    localparam logic [AMP_W-1:0] AMPLITUDE_RST = 16'd32768;

    // Q30 angle and Taylor sum formats
    localparam int unsigned FRAC_W = 30;
    localparam int unsigned ANG_W  = 31;
    localparam int unsigned SUM_W  = 32;
    localparam logic [ANG_W-1:0] PI_HALF_Q30 = 31'd1686629713;

    // Taylor series: six terms after x, divisors (2n)(2n+1)
    localparam int unsigned N_TERMS     = 6;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [7:0] TERM_DIV [N_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [31:0] TERM_RECIP [N_TERMS] = '{
        32'((64'd1 << RECIP_SHIFT) / 64'd6),
        32'((64'd1 << RECIP_SHIFT) / 64'd20),
        32'((64'd1 << RECIP_SHIFT) / 64'd42),
        32'((64'd1 << RECIP_SHIFT) / 64'd72),
        32'((64'd1 << RECIP_SHIFT) / 64'd110),
        32'((64'd1 << RECIP_SHIFT) / 64'd156)
    };

    // One beat of the sine evaluation pipeline.
    // quad[0]: angle mirrored, quad[1]: result negated.
    typedef struct packed {
        logic             valid;
        logic [1:0]       quad;
        logic [ANG_W-1:0] x;
        logic [ANG_W-1:0] term;
        logic [SUM_W-1:0] sum;
    } t_sin_beat;

endpackage

`default_nettype wire

### sv/stsg_div_cell.sv
// One restoring division step: shifts in one dividend bit, subtracts if it fits.
// Depends on nothing; instantiated in rows by stsg_div_chain.
`default_nettype none

module stsg_div_cell #(
    parameter int unsigned DW = 25,
    parameter int unsigned RW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_divisor,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [DW-1:0] i_word,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [DW-1:0]      o_word
);

    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_word;
    logic [RW-1:0] n_rem;
    logic [DW-1:0] n_word;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          fits;

    // Partial remainder stays below the divisor, so trial < 2 * divisor
    assign trial  = {i_rem, i_word[DW-1]};
    assign diff   = trial - {1'b0, i_divisor};
    assign fits   = trial >= {1'b0, i_divisor};
    assign n_rem  = fits ? diff[RW-1:0] : trial[RW-1:0];
    assign n_word = {i_word[DW-2:0], fits};

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_word <= n_word;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;

endmodule

`default_nettype wire

### sv/stsg_div_chain.sv
// Pipelined unsigned divider: a row of DW restoring division cells.
// Depends on stsg_div_cell. Quotient bits come out in the word, remainder alongside.
`default_nettype none

module stsg_div_chain #(
    parameter int unsigned DW = 25,
    parameter int unsigned RW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [RW-1:0] i_divisor,
    output logic               o_valid,
    output logic [DW-1:0]      o_quotient,
    output logic [RW-1:0]      o_remainder
);

    logic          vld  [DW+1];
    logic [RW-1:0] rem  [DW+1];
    logic [DW-1:0] word [DW+1];

    // Head of the row: empty remainder, dividend MSB first
    assign vld[0]  = i_valid;
    assign rem[0]  = '0;
    assign word[0] = i_dividend;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        stsg_div_cell #(
            .DW(DW),
            .RW(RW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (vld[g]),
            .i_divisor(i_divisor),
            .i_rem    (rem[g]),
            .i_word   (word[g]),
            .o_valid  (vld[g+1]),
            .o_rem    (rem[g+1]),
            .o_word   (word[g+1])
        );
    end

    assign o_valid     = vld[DW];
    assign o_quotient  = word[DW];
    assign o_remainder = rem[DW];

endmodule

`default_nettype wire

### sv/stsg_term_cell.sv
// One Taylor series term of sin(x): term * x^2 / ((2n)(2n+1)), added or subtracted.
// Depends on stsg_pkg. Four register stages; chained by the top level.
`default_nettype none

module stsg_term_cell
    import stsg_pkg::*;
#(
    parameter int unsigned TERM = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_sin_beat i_beat,
    output t_sin_beat      o_beat
);

    localparam logic [7:0]  DIV      = TERM_DIV[TERM];
    localparam logic [31:0] RECIP    = TERM_RECIP[TERM];
    localparam bit          SUBTRACT = (TERM % 2) == 0;
    localparam int unsigned PA_W     = 2 * ANG_W;
    localparam int unsigned PB_W     = SUM_W + ANG_W;
    localparam int unsigned NUM_W    = SUM_W + 1;
    localparam int unsigned PC_W     = NUM_W + 32;

    t_sin_beat        r_a_beat, r_b_beat, r_c_beat, r_o_beat;
    t_sin_beat        n_o_beat;
    logic [SUM_W-1:0] r_a_pow;
    logic [NUM_W-1:0] r_b_pow;
    logic [NUM_W-1:0] r_c_num;
    logic [ANG_W-1:0] r_c_quot;
    logic [PA_W-1:0]  prod_a;
    logic [PB_W-1:0]  prod_b;
    logic [PC_W-1:0]  prod_c;
    logic [NUM_W-1:0] back;
    logic [NUM_W-1:0] diff;
    logic [ANG_W-1:0] quot;
    logic [SUM_W-1:0] term_ext;

    // Stage a: term * x
    assign prod_a = PA_W'(i_beat.term) * PA_W'(i_beat.x);

    always_ff @(posedge i_clk) begin
        r_a_pow <= prod_a[FRAC_W +: SUM_W];
        if (!i_rst_n) begin
            r_a_beat <= '0;
        end else begin
            r_a_beat <= i_beat;
        end
    end

    // Stage b: times x again
    assign prod_b = PB_W'(r_a_pow) * PB_W'(r_a_beat.x);

    always_ff @(posedge i_clk) begin
        r_b_pow <= prod_b[FRAC_W +: NUM_W];
        if (!i_rst_n) begin
            r_b_beat <= '0;
        end else begin
            r_b_beat <= r_a_beat;
        end
    end

    // Stage c: quotient estimate by reciprocal, low by at most one
    assign prod_c = PC_W'(r_b_pow) * PC_W'(RECIP);

    always_ff @(posedge i_clk) begin
        r_c_num  <= r_b_pow;
        r_c_quot <= prod_c[RECIP_SHIFT +: ANG_W];
        if (!i_rst_n) begin
            r_c_beat <= '0;
        end else begin
            r_c_beat <= r_b_beat;
        end
    end

    // Stage d: correct the estimate, then update the running sum
    assign back     = NUM_W'(r_c_quot) * NUM_W'(DIV);
    assign diff     = r_c_num - back;
    assign quot     = r_c_quot + ANG_W'(diff >= NUM_W'(DIV));
    assign term_ext = SUM_W'(quot);

    always_comb begin
        n_o_beat      = r_c_beat;
        n_o_beat.term = quot;
        if (SUBTRACT) begin
            n_o_beat.sum = (r_c_beat.sum >= term_ext) ? r_c_beat.sum - term_ext : '0;
        end else begin
            n_o_beat.sum = r_c_beat.sum + term_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_beat <= '0;
        end else begin
            r_o_beat <= n_o_beat;
        end
    end

    assign o_beat = r_o_beat;

endmodule

`default_nettype wire

### sv/sine_table_sample_gen_top.sv
// Top level of the sine table sample generator: config registers, divider rows,
// quadrant fold, Taylor term cells and output scaling. Depends on stsg_pkg and all stsg_ modules.
//
//  channel  | ports                                    | direction | handshake
//  ---------+------------------------------------------+-----------+-----------------------
//  input    | start, busy, i_sample_index              | in        | start && !busy
//  result   | o_strobe, o_sample_code, o_clipped       | out       | o_strobe, one cycle
//  config   | i_cfg_we, i_cfg_index, i_cfg_data        | in        | i_cfg_we, no wait
//
// One beat is taken every cycle while busy is low; the path to a result runs through
// the two restoring divider rows, one quotient bit per cell, then four stages per
// Taylor term.
// Reset is synchronous; busy is high only while reset is held. No clearing pass.
// The receiver cannot stall, so results are never held back.
`default_nettype none

module sine_table_sample_gen_top
    import stsg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IDX_W-1:0]      i_sample_index,
    output logic                       o_strobe,
    output logic [CODE_W-1:0]          o_sample_code,
    output logic                       o_clipped,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned KW         = $clog2(TABLE_DEPTH);
    localparam int unsigned MW         = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned RDW        = CFG_W + MW;
    localparam int unsigned XDW        = MW + ANG_W;
    localparam bit          DEPTH_POW2 = (TABLE_DEPTH == (1 << KW));
    localparam int unsigned X_LAT      = DEPTH_POW2 ? 1 : 2;
    localparam int unsigned LATENCY    = 1 + PROD_W + 1 + RDW + 1 + 1 + X_LAT
                                         + 4 * N_TERMS + 3;
    localparam int unsigned S_W        = 17;
    localparam int unsigned V_W        = 2 * S_W;
    localparam int unsigned NUM_W      = V_W + 12;

    localparam logic [KW+1:0] QD1 = (KW + 2)'(TABLE_DEPTH);
    localparam logic [KW+1:0] QD2 = (KW + 2)'(2 * TABLE_DEPTH);
    localparam logic [KW+1:0] QD3 = (KW + 2)'(3 * TABLE_DEPTH);

    localparam logic signed [NUM_W-1:0] NUM_MID  = NUM_W'(64'd2048 << FRAC_W);
    localparam logic signed [NUM_W-1:0] NUM_HI   = NUM_W'(64'd4095 << FRAC_W);
    localparam logic signed [NUM_W-1:0] SCALE    = NUM_W'(2047);
    localparam logic [SUM_W:0]          ROUND_Q15 = (SUM_W + 1)'(16384);
    localparam logic [17:0]             S_CAP    = 18'd32768;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_points;
    logic [CFG_W-1:0] r_cycles;
    logic [AMP_W-1:0] r_amp;

    // a table length of zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RST;
            r_cycles <= CYCLES_RST;
            r_amp    <= AMPLITUDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINTS: begin
                    r_points <= (i_cfg_data[CFG_W-1:0] == '0) ? CFG_W'(1)
                                                               : i_cfg_data[CFG_W-1:0];
                end
                REG_CYCLES: begin
                    r_cycles <= i_cfg_data[CFG_W-1:0];
                end
                REG_AMPLITUDE: begin
                    r_amp <= i_cfg_data[AMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- input beat: index * cycles ----------------
    logic              accept;
    logic              r_p_valid;
    logic [PROD_W-1:0] r_p;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_sample_index) * PROD_W'(r_cycles);
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= accept;
        end
    end

    // ---------------- r = p mod points ----------------
    logic             a_valid;
    logic [CFG_W-1:0] a_rem;

    stsg_div_chain #(
        .DW(PROD_W),
        .RW(CFG_W)
    ) u_mod_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_p_valid),
        .i_dividend (r_p),
        .i_divisor  (r_points),
        .o_valid    (a_valid),
        .o_quotient (),
        .o_remainder(a_rem)
    );

    // ---------------- k = r * DEPTH / points ----------------
    logic           r_rd_valid;
    logic [RDW-1:0] r_rd;
    logic           b_valid;
    logic [RDW-1:0] b_quot;

    always_ff @(posedge i_clk) begin
        r_rd <= RDW'(a_rem) * RDW'(TABLE_DEPTH);
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= a_valid;
        end
    end

    stsg_div_chain #(
        .DW(RDW),
        .RW(CFG_W)
    ) u_step_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_rd_valid),
        .i_dividend (r_rd),
        .i_divisor  (r_points),
        .o_valid    (b_valid),
        .o_quotient (b_quot),
        .o_remainder()
    );

    // ---------------- quadrant fold ----------------
    logic [KW+1:0] k4;
    logic [KW+1:0] m_raw;
    logic [1:0]    quad;
    logic [MW-1:0] m_fold;
    logic          r_m_valid;
    logic [1:0]    r_m_quad;
    logic [MW-1:0] r_m;

    assign k4 = {b_quot[KW-1:0], 2'b00};

    always_comb begin
        if (k4 >= QD3) begin
            quad  = 2'd3;
            m_raw = k4 - QD3;
        end else if (k4 >= QD2) begin
            quad  = 2'd2;
            m_raw = k4 - QD2;
        end else if (k4 >= QD1) begin
            quad  = 2'd1;
            m_raw = k4 - QD1;
        end else begin
            quad  = 2'd0;
            m_raw = k4;
        end
    end

    // odd quadrants run the angle backward
    assign m_fold = quad[0] ? MW'(TABLE_DEPTH) - MW'(m_raw) : MW'(m_raw);

    always_ff @(posedge i_clk) begin
        r_m      <= m_fold;
        r_m_quad <= quad;
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= b_valid;
        end
    end

    // ---------------- angle x = m * pi/2 / DEPTH (Q30) ----------------
    logic             r_xp_valid;
    logic [1:0]       r_xp_quad;
    logic             x_valid;
    logic [1:0]       x_quad;
    logic [ANG_W-1:0] x_val;

    always_ff @(posedge i_clk) begin
        r_xp_quad <= r_m_quad;
        if (!i_rst_n) begin
            r_xp_valid <= 1'b0;
        end else begin
            r_xp_valid <= r_m_valid;
        end
    end

    if (DEPTH_POW2) begin : g_x_shift
        logic [XDW-1:0]   r_xp;
        logic             r_x_valid;
        logic [1:0]       r_x_quad;
        logic [ANG_W-1:0] r_x;

        always_ff @(posedge i_clk) begin
            r_xp <= XDW'(r_m) * XDW'(PI_HALF_Q30);
        end

        always_ff @(posedge i_clk) begin
            r_x      <= r_xp[KW +: ANG_W];
            r_x_quad <= r_xp_quad;
            if (!i_rst_n) begin
                r_x_valid <= 1'b0;
            end else begin
                r_x_valid <= r_xp_valid;
            end
        end

        assign x_valid = r_x_valid;
        assign x_quad  = r_x_quad;
        assign x_val   = r_x;
    end else begin : g_x_div
        // x = m * (P div D) + (m * (P mod D)) div D, with P = pi/2 in Q30
        localparam logic [ANG_W-1:0] X_A =
            ANG_W'(64'(PI_HALF_Q30) / 64'(TABLE_DEPTH));
        localparam logic [31:0] X_B =
            32'(64'(PI_HALF_Q30) % 64'(TABLE_DEPTH));
        // ceil(2^(32+KW) / D): exact quotient for any 32-bit numerator
        localparam logic [32:0] X_RECIP =
            33'(((64'd1 << (32 + KW)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

        logic [ANG_W-1:0] r_xa;
        logic [31:0]      r_xb;
        logic [64:0]      xb_prod;
        logic             r_xq_valid;
        logic [1:0]       r_xq_quad;
        logic [ANG_W-1:0] r_xq_a;
        logic [KW-1:0]    r_xq;
        logic             r_x_valid;
        logic [1:0]       r_x_quad;
        logic [ANG_W-1:0] r_x;

        // whole and fractional parts of m * P / D
        always_ff @(posedge i_clk) begin
            r_xa <= ANG_W'(r_m) * X_A;
            r_xb <= 32'(r_m) * X_B;
        end

        assign xb_prod = 65'(r_xb) * 65'(X_RECIP);

        // divide the fractional part by reciprocal, then add up
        always_ff @(posedge i_clk) begin
            r_xq_a    <= r_xa;
            r_xq      <= xb_prod[32 + KW +: KW];
            r_xq_quad <= r_xp_quad;
            r_x       <= r_xq_a + ANG_W'(r_xq);
            r_x_quad  <= r_xq_quad;
            if (!i_rst_n) begin
                r_xq_valid <= 1'b0;
                r_x_valid  <= 1'b0;
            end else begin
                r_xq_valid <= r_xp_valid;
                r_x_valid  <= r_xq_valid;
            end
        end

        assign x_valid = r_x_valid;
        assign x_quad  = r_x_quad;
        assign x_val   = r_x;
    end

    // ---------------- Taylor series cells ----------------
    t_sin_beat beat [N_TERMS+1];

    always_comb begin
        beat[0].valid = x_valid;
        beat[0].quad  = x_quad;
        beat[0].x     = x_val;
        beat[0].term  = x_val;
        beat[0].sum   = SUM_W'(x_val);
    end

    for (genvar g = 0; g < N_TERMS; g++) begin : g_term
        stsg_term_cell #(
            .TERM(g)
        ) u_term (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beat (beat[g]),
            .o_beat (beat[g+1])
        );
    end

    // ---------------- Q15 rounding, cap and sign ----------------
    t_sin_beat             fin;
    logic [SUM_W:0]        sum_r;
    logic [17:0]           mag;
    logic [S_W-1:0]        mag_cap;
    logic                  r_s_valid;
    logic signed [S_W-1:0] r_s;

    assign fin     = beat[N_TERMS];
    assign sum_r   = {1'b0, fin.sum} + ROUND_Q15;
    assign mag     = sum_r[SUM_W:15];
    assign mag_cap = (mag > S_CAP) ? S_W'(S_CAP) : S_W'(mag);

    always_ff @(posedge i_clk) begin
        r_s <= fin.quad[1] ? -$signed(mag_cap) : $signed(mag_cap);
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= fin.valid;
        end
    end

    // ---------------- amplitude scaling ----------------
    logic                  r_v_valid;
    logic signed [V_W-1:0] r_v;

    always_ff @(posedge i_clk) begin
        r_v <= V_W'(r_s) * V_W'($signed({1'b0, r_amp}));
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else begin
            r_v_valid <= r_s_valid;
        end
    end

    // ---------------- code = 2048 - 2047 * v, clamped ----------------
    logic signed [NUM_W-1:0] num;
    logic [CODE_W-1:0]       n_code;
    logic                    n_clip;
    logic                    r_strobe;
    logic [CODE_W-1:0]       r_code;
    logic                    r_clip;

    assign num = NUM_MID - NUM_W'(r_v) * SCALE;

    always_comb begin
        if (num > NUM_HI) begin
            n_code = '1;
            n_clip = 1'b1;
        end else if (num < 0) begin
            n_code = '0;
            n_clip = 1'b1;
        end else begin
            n_code = num[FRAC_W +: CODE_W];
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_clip <= n_clip;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v_valid;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_sample_code = r_code;
    assign o_clipped     = r_clip;

    // ---------------- assertions ----------------
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_clipped) |-> (o_sample_code == '0 || o_sample_code == '1))
        else $error("clipped result not at a rail");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("result missing after accepted beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result without an accepted beat");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_valid |-> (x_val <= PI_HALF_Q30))
        else $error("folded angle beyond a quarter turn");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for sine_table_sample_gen_top: directed table, then random phases.
// Depends on stsg_pkg and the sine table sample generator RTL; no files or arguments.
`timescale 1ns / 100ps

module testbench
    import stsg_pkg::*;
();

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int TAIL_CYCLES   = 120;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int N_DIRECTED    = 24;
    localparam int PRINT_CAP     = 30;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam longint Q30_ONE = 64'sd1073741824;

    // One result beat: converter code and clamp flag
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              clipped;
    } t_code_word;

    // One directed row: register setting, index, and an optional typed result
    typedef struct packed {
        logic [CFG_DATA_W-1:0] points;
        logic [CFG_DATA_W-1:0] cycles;
        logic [CFG_DATA_W-1:0] amp;
        logic [IDX_W-1:0]      index;
        logic                  typed;
        logic [CODE_W-1:0]     code;
        logic                  clipped;
    } t_stim_row;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // reset setting: peaks, zero crossings, last index
        '{16'd4096,  16'd1,     16'd32768, 12'd0,    1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd1,     16'd32768, 12'd1024, 1'b0, 12'd0,    1'b0},
        '{16'd4096,  16'd1,     16'd32768, 12'd2048, 1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd1,     16'd32768, 12'd3072, 1'b0, 12'd0,    1'b0},
        '{16'd4096,  16'd1,     16'd32768, 12'd4095, 1'b0, 12'd0,    1'b0},
        '{16'd4096,  16'd1,     16'd32768, 12'd512,  1'b0, 12'd0,    1'b0},
        // zero amplitude
        '{16'd4096,  16'd1,     16'd0,     12'd1024, 1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd1,     16'd0,     12'd3072, 1'b1, 12'd2048, 1'b0},
        // full amplitude clamps at both rails
        '{16'd4096,  16'd1,     16'd65535, 12'd1024, 1'b1, 12'd0,    1'b1},
        '{16'd4096,  16'd1,     16'd65535, 12'd3072, 1'b1, 12'd4095, 1'b1},
        '{16'd4096,  16'd1,     16'd65535, 12'd0,    1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd1,     16'd65535, 12'd512,  1'b0, 12'd0,    1'b0},
        // zero table length acts as one point
        '{16'd0,     16'd1,     16'd32768, 12'd4095, 1'b1, 12'd2048, 1'b0},
        '{16'd0,     16'd4096,  16'd65535, 12'd1234, 1'b1, 12'd2048, 1'b0},
        '{16'd1,     16'd4096,  16'd65535, 12'd4095, 1'b1, 12'd2048, 1'b0},
        // zero cycles, and cycles equal to and just below the table length
        '{16'd4096,  16'd0,     16'd65535, 12'd1024, 1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd4096,  16'd65535, 12'd4095, 1'b1, 12'd2048, 1'b0},
        '{16'd4096,  16'd4095,  16'd40000, 12'd4095, 1'b0, 12'd0,    1'b0},
        // index past the table end wraps, and a three-point table
        '{16'd100,   16'd1,     16'd50000, 12'd150,  1'b0, 12'd0,    1'b0},
        '{16'd3,     16'd1,     16'd65535, 12'd1,    1'b0, 12'd0,    1'b0},
        '{16'd3,     16'd1,     16'd65535, 12'd2,    1'b0, 12'd0,    1'b0},
        // register values above the stated range, and a minimal amplitude
        '{16'hFFFF,  16'hFFFF,  16'd32767, 12'd4095, 1'b0, 12'd0,    1'b0},
        '{16'd8191,  16'd4097,  16'd1,     12'd2047, 1'b0, 12'd0,    1'b0},
        '{16'd4096,  16'd1,     16'd1,     12'd1024, 1'b0, 12'd0,    1'b0}
    };

    // DUT signals, known from time zero
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [IDX_W-1:0]      i_sample_index = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  busy;
    logic                  o_strobe;
    logic [CODE_W-1:0]     o_sample_code;
    logic                  o_clipped;

    // Shadow copy of the configuration registers
    logic [CFG_W-1:0] shadow_points = POINTS_RST;
    logic [CFG_W-1:0] shadow_cycles = CYCLES_RST;
    logic [AMP_W-1:0] shadow_amp    = AMPLITUDE_RST;

    t_code_word pending_codes [$];

    int mismatches      = 0;
    int samples_sent    = 0;
    int results_seen    = 0;
    int clipped_seen    = 0;
    int settings_loaded = 0;

    sine_table_sample_gen_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_index (i_sample_index),
        .o_strobe       (o_strobe),
        .o_sample_code  (o_sample_code),
        .o_clipped      (o_clipped),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Taylor sine to x^13 in Q30, each term truncated after every multiply
    function automatic longint unsigned taylor_sin_q30(input longint unsigned x);
        longint unsigned acc;
        longint unsigned t;
        acc = x;
        t   = x;
        for (int n = 1; n <= 6; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = (acc >= t) ? acc - t : 0;
            else
                acc = acc + t;
        end
        return acc;
    endfunction

    // Expected code for one sample index under the shadow configuration
    function automatic t_code_word predict_code(input logic [IDX_W-1:0] idx);
        longint unsigned ix, pts, cyc, r, k, q, m, x, s;
        longint          sine_s, amp_s, v, num;
        t_code_word      res;
        ix  = idx;
        pts = shadow_points;
        cyc = shadow_cycles;
        if (pts == 0)
            pts = 1;
        r = (ix * cyc) % pts;
        k = (r * TABLE_DEPTH_DEF) / pts;
        // quadrant fold: mirror in odd quadrants, negate in the lower half
        q = (4 * k) / TABLE_DEPTH_DEF;
        m = (4 * k) % TABLE_DEPTH_DEF;
        if (q % 2 == 1)
            m = TABLE_DEPTH_DEF - m;
        x = (m * PI_HALF_Q30) / TABLE_DEPTH_DEF;
        s = (taylor_sin_q30(x) + 16384) >> 15;
        if (s > 32768)
            s = 32768;
        sine_s = (q >= 2) ? -longint'(s) : longint'(s);
        amp_s  = shadow_amp;
        v      = sine_s * amp_s;
        num    = 2048 * Q30_ONE - 2047 * v;
        if (num > 4095 * Q30_ONE) begin
            res.code    = 12'd4095;
            res.clipped = 1'b1;
        end else if (num < 0) begin
            res.code    = '0;
            res.clipped = 1'b1;
        end else begin
            res.code    = CODE_W'(num >>> 30);
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    // Mirror a register write into the shadow copy
    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_POINTS:    shadow_points = CFG_W'(data);
            REG_CYCLES:    shadow_cycles = CFG_W'(data);
            REG_AMPLITUDE: shadow_amp    = AMP_W'(data);
            default: ;
        endcase
    endfunction

    // Write all three registers plus the spare index, one write per beat
    task automatic load_setting(input logic [CFG_DATA_W-1:0] pts,
                                input logic [CFG_DATA_W-1:0] cyc,
                                input logic [CFG_DATA_W-1:0] amp);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{REG_POINTS, REG_CYCLES, REG_AMPLITUDE, REG_SPARE};
        vals = '{pts, cyc, amp, CFG_DATA_W'($urandom)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            shadow_write(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Drive one sample until accepted; start stays high for a following beat
    task automatic send_sample(input logic [IDX_W-1:0]  idx,
                               input logic              typed,
                               input logic [CODE_W-1:0] code,
                               input logic              clipped);
        t_code_word want;
        start          <= 1'b1;
        i_sample_index <= idx;
        do
            @(posedge i_clk);
        while (busy);
        if (typed) begin
            want.code    = code;
            want.clipped = clipped;
        end else begin
            want = predict_code(idx);
        end
        pending_codes.push_back(want);
        samples_sent++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Lower start and wait until every issued sample has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 12'd1024;
            3:       return 12'd2048;
            4:       return 12'd3072;
            default: return IDX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd4096;
            3:       return CFG_DATA_W'($urandom_range(4097, 8191));
            4:       return CFG_DATA_W'($urandom);
            5, 6:    return CFG_DATA_W'($urandom_range(2, 16));
            default: return CFG_DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_amplitude();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd32768;
            3:       return CFG_DATA_W'($urandom_range(32768, 65535));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Result checker: every strobe beat against the oldest expectation
    always @(posedge i_clk) begin
        t_code_word want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (o_clipped)
                clipped_seen++;
            if (pending_codes.size() == 0) begin
                flag_mismatch($sformatf("unexpected result code=%0d clipped=%0b",
                                        o_sample_code, o_clipped));
            end else begin
                want = pending_codes.pop_front();
                if (o_sample_code !== want.code)
                    flag_mismatch($sformatf("sample_code got %0d want %0d",
                                            o_sample_code, want.code));
                if (o_clipped !== want.clipped)
                    flag_mismatch($sformatf("clipped got %0b want %0b",
                                            o_clipped, want.clipped));
            end
        end
    end

    // Main sequence
    initial begin
        int        phase_len;
        int        burst_left;
        int        gap;
        int        drain_cycles;
        t_stim_row row;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; registers start at their reset values
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (CFG_W'(row.points) != shadow_points || CFG_W'(row.cycles) != shadow_cycles ||
                AMP_W'(row.amp) != shadow_amp) begin
                drain_results();
                load_setting(row.points, row.cycles, row.amp);
            end
            send_sample(row.index, row.typed, row.code, row.clipped);
        end

        // Random phases: new setting, then bursts of samples with gaps
        while (samples_sent < N_DIRECTED + RANDOM_ITEMS) begin
            drain_results();
            load_setting(pick_length(), pick_length(), pick_amplitude());
            phase_len  = $urandom_range(30, 150);
            burst_left = $urandom_range(1, 40);
            for (int j = 0; j < phase_len; j++) begin
                send_sample(pick_index(), 1'b0, '0, 1'b0);
                burst_left--;
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    if (gap != 0)
                        hold_off(gap);
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        // Wait for the tail, then look for strays and leftovers
        start <= 1'b0;
        drain_cycles = 0;
        while (pending_codes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_codes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_codes.size()));

        $display("Covered %0d samples (%0d from the directed table) over %0d register settings.",
                 samples_sent, N_DIRECTED, settings_loaded);
        $display("Checked %0d results, %0d of them clamped; %0d mismatches.",
                 results_seen, clipped_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("Watchdog expired with %0d results outstanding", pending_codes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sine_table_sample_gen_top.f
sv/stsg_pkg.sv
sv/stsg_div_cell.sv
sv/stsg_div_chain.sv
sv/stsg_term_cell.sv
sv/sine_table_sample_gen_top.sv
sim/testbench.sv
